>>> src/assert_macros.svh
// Assertion macros shared by the RTL of the echo capture block.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define EPCD_ASSERT(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define EPCD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define EPCD_ASSERT(name, cond, msg)
`define EPCD_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

>>> src/epcd_pkg.sv
// Types and constants of the echo pulse capture block.
// Used by epcd_dist, echo_pulse_capture_distance and tb_top; depends on nothing.
package epcd_pkg;

    typedef struct packed {
        logic        req_type;
        logic        overflow_event;
        logic        capture_event;
        logic [15:0] capture_value;
    } req_t;

    typedef struct packed {
        logic [19:0] distance;
        logic        distance_fresh;
        logic        await_falling;
        logic        restart_counter;
        logic        trigger_pulse;
    } res_t;

    localparam logic        REQ_TIMER = 1'b0;
    localparam logic        REQ_READ  = 1'b1;

    localparam logic [5:0]  OVF_MAX   = 6'h3F;
    localparam logic [15:0] OVF_TIME  = 16'hFFFF;

    // Scale is 170/1000 = 17/100; the division by 100 uses a 2^-32 reciprocal.
    localparam logic [25:0] DIV_MAGIC = 26'd42949672;
    localparam logic [7:0]  DIVISOR   = 8'd100;

endpackage

>>> src/epcd_dist.sv
// Distance scaling: ((overflows * 65536) + time) * 17 / 100, rounded down.
// Depends on epcd_pkg for the reciprocal constants.
module epcd_dist
(
    input  logic [5:0]  ovf_cnt,
    input  logic [15:0] cap_time,
    output logic [19:0] distance
);

    logic [21:0] echo_time;
    logic [26:0] scaled;
    logic [52:0] prod;
    logic [19:0] quot;
    logic [26:0] quot_x100;
    logic [26:0] rem;

    assign echo_time = {ovf_cnt, cap_time};
    assign scaled    = {1'b0, echo_time, 4'b0000} + {5'b00000, echo_time};
    assign prod      = 53'(scaled) * 53'(epcd_pkg::DIV_MAGIC);
    assign quot      = prod[51:32];
    assign quot_x100 = {1'b0, quot, 6'b000000} + {2'b00, quot, 5'b00000}
                     + {5'b00000, quot, 2'b00};
    assign rem       = scaled - quot_x100;

    // The estimate is low by at most one, so a single correction step suffices.
    assign distance  = (rem[7:0] >= epcd_pkg::DIVISOR) ? quot + 20'd1 : quot;

endmodule

>>> src/echo_pulse_capture_distance.sv
// Top level of the ultrasonic echo capture and distance block.
// Depends on epcd_pkg, epcd_dist and assert_macros.svh.
//
//   Channel | Ports                    | Payload
//   request | req_valid, req_stall     | req (epcd_pkg::req_t)
//   result  | res_valid, res_stall     | res (epcd_pkg::res_t)
//
// Each transaction passes through the input register and then the result
// register, and one transaction is taken per cycle while a valid result is not
// held by res_stall. The capture state and
// the distance scaling with its single reciprocal multiplier update in the same
// cycle as the result register loads.
// Reset clears the capture state and both valid flags. A stalled result holds
// the pipeline, and req_stall rises only when the input register cannot move.
module echo_pulse_capture_distance
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  epcd_pkg::req_t    req,
    output logic              res_valid,
    input  logic              res_stall,
    output epcd_pkg::res_t    res
);

    `include "assert_macros.svh"

    logic            s1_valid_reg;
    epcd_pkg::req_t  s1_reg;
    logic            res_valid_reg;
    epcd_pkg::res_t  res_reg;
    epcd_pkg::res_t  res_next;

    logic        armed_reg,    armed_next;
    logic        done_reg,     done_next;
    logic [5:0]  ovf_cnt_reg,  ovf_cnt_next;
    logic [15:0] cap_time_reg, cap_time_next;
    logic        falling_reg,  falling_next;
    logic [19:0] dist_reg,     dist_next;

    logic        res_adv;
    logic        step;
    logic [19:0] new_dist;

    logic        res_fresh;
    logic        read_done;
    logic        capture_idle;

    assign res_adv   = !res_valid_reg || !res_stall;
    assign step      = s1_valid_reg && res_adv;
    assign req_stall = s1_valid_reg && !res_adv;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign res_fresh    = res_valid_reg && res_reg.distance_fresh;
    assign read_done    = step && (s1_reg.req_type == epcd_pkg::REQ_READ) && done_reg;
    assign capture_idle = !done_reg && !armed_reg && (ovf_cnt_reg == '0);

    epcd_dist u_dist
    (
        .ovf_cnt  (ovf_cnt_reg),
        .cap_time (cap_time_reg),
        .distance (new_dist)
    );

    always_comb
    begin
        armed_next    = armed_reg;
        done_next     = done_reg;
        ovf_cnt_next  = ovf_cnt_reg;
        cap_time_next = cap_time_reg;
        falling_next  = falling_reg;
        dist_next     = dist_reg;
        res_next.distance_fresh  = 1'b0;
        res_next.restart_counter = 1'b0;
        res_next.trigger_pulse   = (s1_reg.req_type == epcd_pkg::REQ_READ);

        if (s1_reg.req_type == epcd_pkg::REQ_READ)
        begin
            if (done_reg)
            begin
                dist_next    = new_dist;
                armed_next   = 1'b0;
                done_next    = 1'b0;
                ovf_cnt_next = '0;
                res_next.distance_fresh = 1'b1;
            end
        end
        else if (!done_reg)
        begin
            // The overflow is handled before the edge of the same transaction.
            if (s1_reg.overflow_event && armed_reg)
            begin
                if (ovf_cnt_reg == epcd_pkg::OVF_MAX)
                begin
                    done_next     = 1'b1;
                    cap_time_next = epcd_pkg::OVF_TIME;
                end
                else
                begin
                    ovf_cnt_next = ovf_cnt_reg + 6'd1;
                end
            end
            if (s1_reg.capture_event)
            begin
                if (armed_reg)
                begin
                    done_next     = 1'b1;
                    cap_time_next = s1_reg.capture_value;
                    falling_next  = 1'b0;
                end
                else
                begin
                    ovf_cnt_next  = '0;
                    cap_time_next = '0;
                    armed_next    = 1'b1;
                    falling_next  = 1'b1;
                    res_next.restart_counter = 1'b1;
                end
            end
        end

        res_next.distance      = dist_next;
        res_next.await_falling = falling_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            armed_reg     <= 1'b0;
            done_reg      <= 1'b0;
            ovf_cnt_reg   <= '0;
            cap_time_reg  <= '0;
            falling_reg   <= 1'b0;
            dist_reg      <= '0;
        end
        else
        begin
            if (!req_stall)
            begin
                s1_valid_reg <= req_valid;
            end
            if (res_adv)
            begin
                res_valid_reg <= s1_valid_reg;
            end
            if (step)
            begin
                armed_reg    <= armed_next;
                done_reg     <= done_next;
                ovf_cnt_reg  <= ovf_cnt_next;
                cap_time_reg <= cap_time_next;
                falling_reg  <= falling_next;
                dist_reg     <= dist_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            s1_reg <= req;
        end
        if (step)
        begin
            res_reg <= res_next;
        end
    end

    `EPCD_ASSERT(a_done_needs_armed, !done_reg || armed_reg, "capture done while not armed")
    `EPCD_ASSERT(a_count_needs_armed, (ovf_cnt_reg == '0) || armed_reg, "count while idle")
    `EPCD_ASSERT(a_fresh_on_read, !res_fresh || res_reg.trigger_pulse, "fresh result not a read")
    `EPCD_ASSERT_NEXT(a_read_clears, read_done, capture_idle, "read did not clear the capture")

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for echo_pulse_capture_distance: directed and random
// timer and read transactions, checked against a cycle-free model of the capture.
// Depends on epcd_pkg and the RTL of the block only.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int TARGET_ITEMS = 1550;
    localparam int HOLDOFF_AT   = 150;
    localparam int HOLDOFF_LEN  = 120;
    localparam int DRAIN_CYCLES = 10;

    logic clk;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    epcd_pkg::req_t req = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    epcd_pkg::res_t res;

    echo_pulse_capture_distance dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    epcd_pkg::req_t echo_requests[$];
    epcd_pkg::res_t expected_echo_results[$];
    epcd_pkg::res_t oldest_expected;
    int          reqs_accepted  = 0;
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          holdoff_left   = 0;
    logic        holdoff_begun  = 1'b0;
    logic [1:0]  traffic_phase;
    logic [6:0]  send_gap_pct;
    logic [6:0]  recv_stall_pct;

    // Shadow copy of the capture state.
    logic        echo_armed     = 1'b0;
    logic        echo_done      = 1'b0;
    logic [5:0]  ovf_count      = '0;
    logic [15:0] edge_time      = '0;
    logic        falling_sel    = 1'b0;
    logic [19:0] last_dist      = '0;

    function automatic epcd_pkg::res_t predict_echo_result(epcd_pkg::req_t r);
        epcd_pkg::res_t o;
        logic [21:0]    echo_ticks;
        logic [31:0]    scaled;
        logic           finishing_armed;
        o = '0;
        if (r.req_type == epcd_pkg::REQ_READ)
        begin
            if (echo_done)
            begin
                echo_ticks = {ovf_count, edge_time};
                scaled = ({10'd0, echo_ticks} * 32'd170) / 32'd1000;
                last_dist = scaled[19:0];
                o.distance_fresh = 1'b1;
                echo_armed = 1'b0;
                echo_done = 1'b0;
                ovf_count = '0;
            end
        end
        else if (!echo_done)
        begin
            finishing_armed = echo_armed;
            if (r.overflow_event && echo_armed)
            begin
                if (ovf_count == epcd_pkg::OVF_MAX)
                begin
                    echo_done = 1'b1;
                    edge_time = epcd_pkg::OVF_TIME;
                end
                else
                begin
                    ovf_count = ovf_count + 6'd1;
                end
            end
            if (r.capture_event)
            begin
                if (finishing_armed)
                begin
                    echo_done = 1'b1;
                    edge_time = r.capture_value;
                    falling_sel = 1'b0;
                end
                else
                begin
                    ovf_count = '0;
                    edge_time = '0;
                    echo_armed = 1'b1;
                    o.restart_counter = 1'b1;
                    falling_sel = 1'b1;
                end
            end
        end
        o.distance = last_dist;
        o.await_falling = falling_sel;
        o.trigger_pulse = (r.req_type == epcd_pkg::REQ_READ);
        return o;
    endfunction

    function automatic logic coin();
        logic [31:0] rnd;
        rnd = $urandom;
        return rnd[0];
    endfunction

    function automatic logic [15:0] pick_value();
        logic [31:0] rnd;
        rnd = $urandom;
        case ($urandom_range(3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return rnd[15:0];
        endcase
    endfunction

    task automatic queue_timer_event(logic ovf, logic cap, logic [15:0] value);
        epcd_pkg::req_t r;
        r.req_type = epcd_pkg::REQ_TIMER;
        r.overflow_event = ovf;
        r.capture_event = cap;
        r.capture_value = value;
        echo_requests.push_back(r);
    endtask

    task automatic queue_read_request();
        epcd_pkg::req_t r;
        r = '0;
        r.req_type = epcd_pkg::REQ_READ;
        r.overflow_event = coin();
        r.capture_event = coin();
        r.capture_value = pick_value();
        echo_requests.push_back(r);
    endtask

    task automatic queue_measurement(int n_ovf, logic with_stop, logic stop_ovf,
                                     logic [15:0] stop_value);
        logic [31:0] rnd;
        int          extra;
        queue_timer_event(coin(), 1'b1, pick_value());
        for (int i = 0; i < n_ovf; i++)
        begin
            queue_timer_event(1'b1, 1'b0, pick_value());
            if ($urandom_range(7) == 0)
            begin
                if (coin())
                    queue_read_request();
                else
                    queue_timer_event(1'b0, 1'b0, pick_value());
            end
        end
        if (with_stop)
            queue_timer_event(stop_ovf, 1'b1, stop_value);
        extra = $urandom_range(2);
        for (int i = 0; i < extra; i++)
        begin
            rnd = $urandom;
            queue_timer_event(rnd[0], rnd[1], rnd[17:2]);
        end
        queue_read_request();
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always_comb
    begin
        if (reqs_accepted >= 1200)
            traffic_phase = 2'd3;
        else
            traffic_phase = 2'(reqs_accepted / 400);
        case (traffic_phase)
            2'd1: send_gap_pct = 7'd50;
            2'd3: send_gap_pct = 7'd22;
            default: send_gap_pct = 7'd0;
        endcase
        case (traffic_phase)
            2'd2: recv_stall_pct = 7'd50;
            2'd3: recv_stall_pct = 7'd22;
            default: recv_stall_pct = 7'd0;
        endcase
    end

    // Request driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                expected_echo_results.push_back(predict_echo_result(req));
                reqs_accepted <= reqs_accepted + 1;
            end
            if (req_valid && req_stall)
            begin
                req_valid <= 1'b1;
            end
            else if (echo_requests.size() != 0 && $urandom_range(99) >= send_gap_pct)
            begin
                req_valid <= 1'b1;
                req <= echo_requests.pop_front();
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // Result stall, with one long hold-off early in the run so the pipeline backs up.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            holdoff_left <= 0;
            holdoff_begun <= 1'b0;
        end
        else if (!holdoff_begun && reqs_accepted >= HOLDOFF_AT)
        begin
            holdoff_begun <= 1'b1;
            holdoff_left <= HOLDOFF_LEN;
            res_stall <= 1'b1;
        end
        else if (holdoff_left != 0)
        begin
            holdoff_left <= holdoff_left - 1;
            res_stall <= 1'b1;
        end
        else
        begin
            res_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_echo_results.size() == 0)
            begin
                $display("%0t: unexpected result transaction, actual %h", $time, res);
                mismatch_count++;
            end
            else
            begin
                oldest_expected = expected_echo_results.pop_front();
                if (res.distance !== oldest_expected.distance)
                begin
                    $display("%0t: distance expected %0d actual %0d", $time,
                             oldest_expected.distance, res.distance);
                    mismatch_count++;
                end
                if (res.distance_fresh !== oldest_expected.distance_fresh)
                begin
                    $display("%0t: distance_fresh expected %b actual %b", $time,
                             oldest_expected.distance_fresh, res.distance_fresh);
                    mismatch_count++;
                end
                if (res.await_falling !== oldest_expected.await_falling)
                begin
                    $display("%0t: await_falling expected %b actual %b", $time,
                             oldest_expected.await_falling, res.await_falling);
                    mismatch_count++;
                end
                if (res.restart_counter !== oldest_expected.restart_counter)
                begin
                    $display("%0t: restart_counter expected %b actual %b", $time,
                             oldest_expected.restart_counter, res.restart_counter);
                    mismatch_count++;
                end
                if (res.trigger_pulse !== oldest_expected.trigger_pulse)
                begin
                    $display("%0t: trigger_pulse expected %b actual %b", $time,
                             oldest_expected.trigger_pulse, res.trigger_pulse);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("echo_pulse_capture_distance regression: fail");
            $finish;
        end
    end

    initial
    begin
        // Directed part.
        queue_read_request();
        queue_timer_event(1'b1, 1'b0, 16'h0000);
        queue_timer_event(1'b0, 1'b0, 16'hFFFF);
        queue_timer_event(1'b1, 1'b1, 16'hFFFF);
        queue_read_request();
        queue_timer_event(1'b1, 1'b0, 16'h1234);
        queue_timer_event(1'b0, 1'b1, 16'h0000);
        queue_timer_event(1'b0, 1'b1, 16'h5555);
        queue_timer_event(1'b1, 1'b0, 16'hAAAA);
        queue_read_request();
        queue_read_request();
        queue_timer_event(1'b0, 1'b1, 16'hAAAA);
        queue_timer_event(1'b1, 1'b1, 16'hFFFF);
        queue_read_request();
        queue_timer_event(1'b0, 1'b1, 16'h0000);
        queue_timer_event(1'b0, 1'b1, 16'h0000);
        queue_read_request();
        queue_timer_event(1'b0, 1'b1, 16'h1234);
        queue_timer_event(1'b0, 1'b1, 16'h0001);
        queue_read_request();
        // Longest echo, a finish by overflow, and an overflow finish with an edge on top.
        queue_measurement(63, 1'b1, 1'b0, 16'hFFFF);
        queue_measurement(64, 1'b0, 1'b0, 16'h0000);
        queue_measurement(63, 1'b1, 1'b1, 16'h8001);

        // Random part.
        while (echo_requests.size() < TARGET_ITEMS)
        begin
            int          sel;
            int          n_noise;
            logic [31:0] rnd;
            sel = $urandom_range(99);
            if (sel < 72)
            begin
                queue_measurement($urandom_range(4), ($urandom_range(9) != 0), coin(),
                                  pick_value());
            end
            else if (sel < 84)
            begin
                queue_measurement($urandom_range(66, 60), coin(), coin(), pick_value());
            end
            else
            begin
                n_noise = $urandom_range(6, 1);
                for (int i = 0; i < n_noise; i++)
                begin
                    rnd = $urandom;
                    echo_requests.push_back(epcd_pkg::req_t'(rnd[18:0]));
                end
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (echo_requests.size() != 0 || req_valid || expected_echo_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("echo_pulse_capture_distance regression: pass");
        else
            $display("echo_pulse_capture_distance regression: fail");
        $finish;
    end

endmodule
